@@ design/pdts_pkg.sv @@
package pdts_pkg;

  // Datapath widths.
  localparam int DATA_W  = 32;          // Q16.16 ports and gains
  localparam int BAND_W  = 31;          // deadband and knee
  localparam int ERR_W   = 33;          // target - measured
  localparam int DIFF_W  = ERR_W + 1;   // error - previous error
  localparam int SUM_W   = 48;          // integral accumulator
  localparam int QX_W    = SUM_W + 1;   // multiplier value operand
  localparam int PROD_W  = 48;          // saturated product
  localparam int ADDR_W  = 5;           // APB byte address

  // Reset values of the configuration registers.
  localparam logic signed [DATA_W-1:0] KP_RESET      = 32'sd65536;
  localparam logic signed [DATA_W-1:0] OUT_MIN_RESET = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] OUT_MAX_RESET = 32'sh7FFF_FFFF;

  // Default integral limits.
  localparam logic signed [SUM_W-1:0] INTEGRAL_LOW_DEF  = -48'sd2147483648;
  localparam logic signed [SUM_W-1:0] INTEGRAL_HIGH_DEF = 48'sd2147483647;

  // Register map, one 32-bit word each.
  typedef enum logic [2:0] {
    REG_DEADBAND   = 3'd0,
    REG_KNEE       = 3'd1,
    REG_KP_INNER   = 3'd2,
    REG_KP_OUTER   = 3'd3,
    REG_KI_DT      = 3'd4,
    REG_KD_OVER_DT = 3'd5,
    REG_DRIVE_LO   = 3'd6,
    REG_DRIVE_HI   = 3'd7
  } pdts_reg_e;

  // Load enables for the three stages of a product unit.
  typedef struct packed {
    logic ld_abs;
    logic ld_prod;
    logic ld_res;
  } pdts_adv_t;

endpackage

@@ design/pdts_if.sv @@
// Input beat: setpoint, measurement and history clear.
interface pdts_in_if;
  import pdts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] measured;
  logic                     clear_history;

  modport source (output valid, output target, output measured, output clear_history,
                  input ready);
  modport sink (input valid, input target, input measured, input clear_history,
                output ready);
endinterface

// Output beat: clamped drive value.
interface pdts_out_if;
  import pdts_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

@@ design/pid_deadband_two_slope.sv @@
// PID controller with a symmetric deadband and a two-slope proportional gain, all in signed
// Q16.16. One item (target, measured, clear_history) gives one drive beat. The datapath is a
// nine-stage register pipeline, so a new item is taken every clock unless all stages are full,
// and its drive value leaves from drive_q; the integral and previous-error state is
// updated in a single stage, which closes the only loop back to back. Bubbles close up under
// output back-pressure, so input is refused only when all nine stages are full. Registers sit
// on the APB port at byte address 4*i: deadband, knee, kp_inner, kp_outer, ki_dt,
// kd_over_dt, drive low limit, drive high limit. Write them only while no item is in flight.
module pid_deadband_two_slope import pdts_pkg::*; #(
  parameter logic signed [SUM_W-1:0] INTEGRAL_LOW  = INTEGRAL_LOW_DEF,
  parameter logic signed [SUM_W-1:0] INTEGRAL_HIGH = INTEGRAL_HIGH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pdts_in_if.sink            in_i,
  pdts_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int NUM_ST  = 9;
  localparam int ST_IN   = 0;
  localparam int ST_ERR  = 1;
  localparam int ST_SUM  = 2;
  localparam int ST_ABS  = 3;
  localparam int ST_PROD = 4;
  localparam int ST_RES  = 5;
  localparam int ST_PSUM = 6;
  localparam int ST_SIGN = 7;
  localparam int ST_OUT  = 8;
  localparam int PSUM_W  = PROD_W + 1;
  localparam int PN_W    = PROD_W + 2;
  localparam int TOT_W   = PROD_W + 3;
  localparam int ACC_W   = SUM_W + 1;

  // Configuration registers and values derived from them.
  logic [BAND_W-1:0]        deadband_q, knee_q, sb_q, sbdb_q;
  logic signed [DATA_W-1:0] kp_inner_q, kp_outer_q, ki_dt_q, kd_over_dt_q;
  logic signed [DATA_W-1:0] drive_lo_q, drive_hi_q, hi_lim_q;
  logic [BAND_W-1:0]        sb_d;
  logic                     wr_en;
  pdts_reg_e                reg_sel;

  // Pipeline control.
  logic [NUM_ST-1:0]        v_q;
  logic [NUM_ST-1:0]        en;
  pdts_adv_t                adv;

  // Controller state.
  logic signed [SUM_W-1:0]  esum_q, esum_d;
  logic signed [ERR_W-1:0]  last_q;

  // Stage payloads.
  logic signed [DATA_W-1:0] t0_q, m0_q;
  logic                     clr0_q, clr1_q;
  logic signed [ERR_W-1:0]  err1_q;
  logic [ERR_W-1:0]         mag1_q;
  logic signed [ERR_W-1:0]  tm_d, mt_d;
  logic signed [DIFF_W-1:0] diff2_q;
  logic [ERR_W-1:0]         xa2_q, xb2_q, xa_d, xb_d;
  logic                     neg2_q, neg3_q, neg4_q, neg5_q, neg6_q;
  logic signed [PROD_W-1:0] pa, pb, pi, pd;
  logic signed [PSUM_W-1:0] psum6_q, id7_q;
  logic signed [PROD_W-1:0] i6_q, d6_q;
  logic signed [PN_W-1:0]   pn7_q;
  logic signed [TOT_W-1:0]  total;
  logic signed [DATA_W-1:0] drive_q, drive_d;
  logic signed [SUM_W-1:0]  base_sum;
  logic signed [ERR_W-1:0]  base_last;
  logic signed [ACC_W-1:0]  acc;
  logic                     outer, inner;

  // APB write decode; the port never waits.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = pdts_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q   <= '0;
      knee_q       <= '0;
      kp_inner_q   <= KP_RESET;
      kp_outer_q   <= KP_RESET;
      ki_dt_q      <= '0;
      kd_over_dt_q <= '0;
      drive_lo_q   <= OUT_MIN_RESET;
      drive_hi_q   <= OUT_MAX_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_DEADBAND:   deadband_q   <= pwdata[BAND_W-1:0];
        REG_KNEE:       knee_q       <= pwdata[BAND_W-1:0];
        REG_KP_INNER:   kp_inner_q   <= pwdata;
        REG_KP_OUTER:   kp_outer_q   <= pwdata;
        REG_KI_DT:      ki_dt_q      <= pwdata;
        REG_KD_OVER_DT: kd_over_dt_q <= pwdata;
        REG_DRIVE_LO:   drive_lo_q   <= pwdata;
        REG_DRIVE_HI:   drive_hi_q   <= pwdata;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_DEADBAND:   prdata = DATA_W'(deadband_q);
      REG_KNEE:       prdata = DATA_W'(knee_q);
      REG_KP_INNER:   prdata = kp_inner_q;
      REG_KP_OUTER:   prdata = kp_outer_q;
      REG_KI_DT:      prdata = ki_dt_q;
      REG_KD_OVER_DT: prdata = kd_over_dt_q;
      REG_DRIVE_LO:   prdata = drive_lo_q;
      REG_DRIVE_HI:   prdata = drive_hi_q;
    endcase
  end

  // A break below the deadband acts as the deadband; inverted limits pin to the minimum.
  assign sb_d = (knee_q < deadband_q) ? deadband_q : knee_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q     <= '0;
      sbdb_q   <= '0;
      hi_lim_q <= OUT_MAX_RESET;
    end else begin
      sb_q     <= sb_d;
      sbdb_q   <= sb_d - deadband_q;
      hi_lim_q <= (drive_hi_q > drive_lo_q) ? drive_hi_q : drive_lo_q;
    end
  end

  // A stage loads when it is empty or the stage after it loads too.
  always_comb begin
    en[ST_OUT] = !v_q[ST_OUT] || out_o.ready;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready  = en[ST_IN];
  assign out_o.valid = v_q[ST_OUT];
  assign out_o.drive = drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[ST_IN]) begin
        v_q[ST_IN] <= in_i.valid;
      end
      for (int k = 1; k < NUM_ST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Input stage.
  always_ff @(posedge clk_i) begin
    if (en[ST_IN]) begin
      t0_q   <= in_i.target;
      m0_q   <= in_i.measured;
      clr0_q <= in_i.clear_history;
    end
  end

  // Error and its magnitude, both directions subtracted side by side.
  assign tm_d = ERR_W'(t0_q) - ERR_W'(m0_q);
  assign mt_d = ERR_W'(m0_q) - ERR_W'(t0_q);

  always_ff @(posedge clk_i) begin
    if (en[ST_ERR]) begin
      err1_q <= tm_d;
      mag1_q <= tm_d[ERR_W-1] ? mt_d : tm_d;
      clr1_q <= clr0_q;
    end
  end

  // Integral update, derivative difference and proportional operands.
  always_comb begin
    base_sum  = clr1_q ? '0 : esum_q;
    base_last = clr1_q ? '0 : last_q;
    acc       = ACC_W'(base_sum) + ACC_W'(err1_q);
    priority if (acc > ACC_W'(INTEGRAL_HIGH)) begin
      esum_d = INTEGRAL_HIGH;
    end else if (acc < ACC_W'(INTEGRAL_LOW)) begin
      esum_d = INTEGRAL_LOW;
    end else begin
      esum_d = SUM_W'(acc);
    end
    outer = mag1_q > ERR_W'(sb_q);
    inner = mag1_q > ERR_W'(deadband_q);
    xa_d  = outer ? mag1_q - ERR_W'(sb_q) : '0;
    priority if (outer) begin
      xb_d = ERR_W'(sbdb_q);
    end else if (inner) begin
      xb_d = mag1_q - ERR_W'(deadband_q);
    end else begin
      xb_d = '0;
    end
  end

  // The history registers move only with a real item entering this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      last_q <= '0;
    end else if (en[ST_SUM] && v_q[ST_ERR]) begin
      esum_q <= esum_d;
      last_q <= err1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_SUM]) begin
      diff2_q <= DIFF_W'(err1_q) - DIFF_W'(base_last);
      xa2_q   <= xa_d;
      xb2_q   <= xb_d;
      neg2_q  <= err1_q[ERR_W-1];
    end
  end

  // Four product units run side by side.
  assign adv.ld_abs  = en[ST_ABS];
  assign adv.ld_prod = en[ST_PROD];
  assign adv.ld_res  = en[ST_RES];

  pdts_qmul u_qmul_outer (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .gain_i (kp_outer_q),
    .x_i    (QX_W'(xa2_q)),
    .prod_o (pa)
  );

  pdts_qmul u_qmul_inner (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .gain_i (kp_inner_q),
    .x_i    (QX_W'(xb2_q)),
    .prod_o (pb)
  );

  pdts_qmul u_qmul_integ (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .gain_i (ki_dt_q),
    .x_i    (QX_W'(esum_q)),
    .prod_o (pi)
  );

  pdts_qmul u_qmul_deriv (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .gain_i (kd_over_dt_q),
    .x_i    (QX_W'(diff2_q)),
    .prod_o (pd)
  );

  // Carry the error sign alongside the product units.
  always_ff @(posedge clk_i) begin
    if (en[ST_ABS]) begin
      neg3_q <= neg2_q;
    end
    if (en[ST_PROD]) begin
      neg4_q <= neg3_q;
    end
    if (en[ST_RES]) begin
      neg5_q <= neg4_q;
    end
  end

  // Proportional sum of both slopes.
  always_ff @(posedge clk_i) begin
    if (en[ST_PSUM]) begin
      psum6_q <= PSUM_W'(pa) + PSUM_W'(pb);
      i6_q    <= pi;
      d6_q    <= pd;
      neg6_q  <= neg5_q;
    end
  end

  // Proportional term takes the error sign; integral and derivative are summed.
  always_ff @(posedge clk_i) begin
    if (en[ST_SIGN]) begin
      pn7_q <= neg6_q ? -PN_W'(psum6_q) : PN_W'(psum6_q);
      id7_q <= PSUM_W'(i6_q) + PSUM_W'(d6_q);
    end
  end

  // Final sum and output clamp.
  always_comb begin
    total = TOT_W'(pn7_q) + TOT_W'(id7_q);
    priority if (total > TOT_W'(hi_lim_q)) begin
      drive_d = hi_lim_q;
    end else if (total < TOT_W'(drive_lo_q)) begin
      drive_d = drive_lo_q;
    end else begin
      drive_d = DATA_W'(total);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      drive_q <= drive_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The integral accumulator never leaves its limits.
  a_esum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esum_q >= INTEGRAL_LOW && esum_q <= INTEGRAL_HIGH)
    else $error("integral accumulator outside its limits");

  // History changes only when a real item enters the integral stage.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(en[ST_SUM] && v_q[ST_ERR]) |=> $stable(esum_q) && $stable(last_q))
    else $error("controller history changed without an item");

  // Input is refused only when every stage holds an item.
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> &v_q)
    else $error("input refused while the pipeline has a bubble");
`endif

endmodule

@@ design/pdts_qmul.sv @@
// Q16.16 gain times value, truncated toward zero and saturated to 48 bits.
// Three register stages: magnitudes, partial products, combine and saturate.
module pdts_qmul import pdts_pkg::*; (
  input  logic                     clk_i,
  input  pdts_adv_t                adv_i,
  input  logic signed [DATA_W-1:0] gain_i,
  input  logic signed [QX_W-1:0]   x_i,
  output logic signed [PROD_W-1:0] prod_o
);

  localparam int LO_W  = 32;
  localparam int HI_W  = QX_W - LO_W;
  localparam int PH_W  = DATA_W + HI_W;
  localparam int PL_W  = DATA_W + LO_W;
  localparam int FRAC  = 16;
  localparam int MAG_W = PROD_W + 1;
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (PROD_W - 1);
  localparam logic [MAG_W-1:0] POS_LIM = NEG_LIM - MAG_W'(1);

  logic              neg1_q, neg2_q;
  logic [DATA_W-1:0] ug_q;
  logic [QX_W-1:0]   ux_q;
  logic [PH_W-1:0]   ph_q;
  logic [PL_W-1:0]   pl_q;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mag_lim;
  logic              sat;

  // Stage one: signs and magnitudes of both operands.
  always_ff @(posedge clk_i) begin
    if (adv_i.ld_abs) begin
      neg1_q <= gain_i[DATA_W-1] ^ x_i[QX_W-1];
      ug_q   <= gain_i[DATA_W-1] ? DATA_W'(-gain_i) : DATA_W'(gain_i);
      ux_q   <= x_i[QX_W-1] ? QX_W'(-x_i) : QX_W'(x_i);
    end
  end

  // Stage two: the gain times the high and low parts of the value.
  always_ff @(posedge clk_i) begin
    if (adv_i.ld_prod) begin
      neg2_q <= neg1_q;
      ph_q   <= PH_W'(ug_q) * PH_W'(ux_q[QX_W-1:LO_W]);
      pl_q   <= PL_W'(ug_q) * PL_W'(ux_q[LO_W-1:0]);
    end
  end

  // Stage three: drop the fraction, saturate and restore the sign.
  always_comb begin
    sat = |ph_q[PH_W-1:DATA_W-1];
    mag = sat ? NEG_LIM
              : MAG_W'({ph_q[DATA_W-2:0], FRAC'(0)}) + MAG_W'(pl_q[PL_W-1:FRAC]);
    if (neg2_q) begin
      mag_lim = (mag > NEG_LIM) ? NEG_LIM : mag;
    end else begin
      mag_lim = (mag > POS_LIM) ? POS_LIM : mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ld_res) begin
      prod_o <= neg2_q ? PROD_W'(-mag_lim) : PROD_W'(mag_lim);
    end
  end

endmodule
